// ===== rtl/mrwq_pkg.sv =====
package mrwq_pkg;

    // bank geometry
    localparam int NUM_QUEUES = 8;
    localparam int DEPTH      = 8;
    localparam int GEN_WIDTH  = 16;
    localparam int SLOTS      = NUM_QUEUES * DEPTH;

    // fixed field widths
    localparam int CMD_W     = 2;
    localparam int SEC_W     = 3;
    localparam int HANDLE_W  = 32;
    localparam int CREATOR_W = 16;
    localparam int STATUS_W  = 2;
    localparam int CFG_W     = 4;

    // derived widths
    localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int LIM_W  = $clog2(NUM_QUEUES + 1);

    // active queue count after reset
    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(8);

    // command queue between front and back
    localparam int CQ_DEPTH = 2;
    localparam int CQ_PTR_W = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ    = 2'd0,
        CMD_ISSUE  = 2'd1,
        CMD_RETIRE = 2'd2,
        CMD_FLUSH  = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_BAD   = 2'd3
    } status_t;

    // classification made by the front
    typedef enum logic [1:0] {
        KIND_QUEUE = 2'd0,
        KIND_FLUSH = 2'd1,
        KIND_BAD   = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t                 kind;
        cmd_t                  cmd;
        logic [SEC_W-1:0]      section;
        logic [HANDLE_W-1:0]   handle;
        logic [CREATOR_W-1:0]  creator;
    } cmd_item_t;

endpackage

// ===== rtl/multi_ring_write_queue_with_flush.sv =====
// Bank of eight ring queues of eight slots each, with a generation flush.
// Command channel: a transaction is taken at a rising edge with start high
// and busy low; cmd selects enqueue, issue head, retire head or flush, and
// section, handle and creator go with it. busy is high only while the
// two-entry command queue between the front and the execution unit is full.
// Result channel: done is high for exactly one cycle per transaction, in
// order, with status, head_handle, head_creator and flush_busy valid in that
// cycle. The receiver cannot stall; results are never held back or dropped.
// Sequence: an enqueue, flush, rejected or empty command and a retire that
// empties its queue go from idle to the response state; an issue and a
// retire that leaves entries pass through a read state for the new head slot.
// Flow: the execution sequencer takes a new command only from idle, once the
// last result is out; its read state waits on the registered slot memory read.
// Configuration: cfg_we with cfg_wdata writes the active queue count; write
// it only while no transaction is in flight.
// Reset clears all queue pointers, the generation, the command queue and the
// result strobe, and sets the active count to 8; slot contents are undefined
// until written and no clearing pass runs, so start may be raised at once.
module multi_ring_write_queue_with_flush (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [mrwq_pkg::CMD_W-1:0]         cmd,
    input  logic [mrwq_pkg::SEC_W-1:0]         section,
    input  logic [mrwq_pkg::HANDLE_W-1:0]      handle,
    input  logic [mrwq_pkg::CREATOR_W-1:0]     creator,
    input  logic                               cfg_we,
    input  logic [mrwq_pkg::CFG_W-1:0]         cfg_wdata,
    output logic                               done,
    output logic [mrwq_pkg::STATUS_W-1:0]      status,
    output logic [mrwq_pkg::HANDLE_W-1:0]      head_handle,
    output logic [mrwq_pkg::CREATOR_W-1:0]     head_creator,
    output logic                               flush_busy
);

    mrwq_pkg::cmd_item_t              front_item;
    mrwq_pkg::cmd_item_t              head_item;
    logic [mrwq_pkg::LIM_W-1:0]       active_limit;
    logic                             cq_empty;
    logic                             cq_full;
    logic                             cq_pop;

    assign busy = cq_full;

    // front: config register and classification
    mrwq_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .section      (section),
        .handle       (handle),
        .creator      (creator),
        .item         (front_item),
        .active_limit (active_limit)
    );

    // command queue between front and back
    mrwq_cmd_queue u_cmd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (start),
        .push_item (front_item),
        .pop       (cq_pop),
        .head_item (head_item),
        .empty     (cq_empty),
        .full      (cq_full)
    );

    // back: queue pointers, slot memory and results
    mrwq_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (head_item),
        .item_avail   (!cq_empty),
        .active_limit (active_limit),
        .item_pop     (cq_pop),
        .done         (done),
        .status       (status),
        .head_handle  (head_handle),
        .head_creator (head_creator),
        .flush_busy   (flush_busy)
    );

endmodule

// ===== rtl/mrwq_front.sv =====
module mrwq_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [mrwq_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic [mrwq_pkg::CMD_W-1:0]         cmd,
    input  logic [mrwq_pkg::SEC_W-1:0]         section,
    input  logic [mrwq_pkg::HANDLE_W-1:0]      handle,
    input  logic [mrwq_pkg::CREATOR_W-1:0]     creator,
    output mrwq_pkg::cmd_item_t                item,
    output logic [mrwq_pkg::LIM_W-1:0]         active_limit
);

    logic [mrwq_pkg::CFG_W-1:0] active_reg;
    logic [mrwq_pkg::CFG_W-1:0] active_next;
    logic                       bad_section;

    // active queue count register
    always_comb
    begin
        active_next = active_reg;
        if (cfg_we)
        begin
            active_next = cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= mrwq_pkg::ACTIVE_RESET;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    // clamp to the number of queues built
    always_comb
    begin
        if (int'(active_reg) > mrwq_pkg::NUM_QUEUES)
        begin
            active_limit = mrwq_pkg::LIM_W'(mrwq_pkg::NUM_QUEUES);
        end
        else
        begin
            active_limit = mrwq_pkg::LIM_W'(active_reg);
        end
    end

    assign bad_section = int'(section) >= int'(active_limit);

    // classify the transaction
    always_comb
    begin
        item.cmd     = mrwq_pkg::cmd_t'(cmd);
        item.section = section;
        item.handle  = handle;
        item.creator = creator;
        if (item.cmd == mrwq_pkg::CMD_FLUSH)
        begin
            item.kind = mrwq_pkg::KIND_FLUSH;
        end
        else if (bad_section)
        begin
            item.kind = mrwq_pkg::KIND_BAD;
        end
        else
        begin
            item.kind = mrwq_pkg::KIND_QUEUE;
        end
    end

endmodule

// ===== rtl/mrwq_cmd_queue.sv =====
module mrwq_cmd_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mrwq_pkg::cmd_item_t  push_item,
    input  logic                 pop,
    output mrwq_pkg::cmd_item_t  head_item,
    output logic                 empty,
    output logic                 full
);

    mrwq_pkg::cmd_item_t               entry_reg [mrwq_pkg::CQ_DEPTH];
    logic [mrwq_pkg::CQ_PTR_W-1:0]     wr_ptr_reg;
    logic [mrwq_pkg::CQ_PTR_W-1:0]     wr_ptr_next;
    logic [mrwq_pkg::CQ_PTR_W-1:0]     rd_ptr_reg;
    logic [mrwq_pkg::CQ_PTR_W-1:0]     rd_ptr_next;
    logic [mrwq_pkg::CQ_CNT_W-1:0]     count_reg;
    logic [mrwq_pkg::CQ_CNT_W-1:0]     count_next;
    logic                              do_push;
    logic                              do_pop;

    function automatic logic [mrwq_pkg::CQ_PTR_W-1:0] bump(
        input logic [mrwq_pkg::CQ_PTR_W-1:0] p
    );
        if (int'(p) == mrwq_pkg::CQ_DEPTH - 1)
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign empty     = (count_reg == '0);
    assign full      = (int'(count_reg) == mrwq_pkg::CQ_DEPTH);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_item = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/mrwq_back.sv =====
module mrwq_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mrwq_pkg::cmd_item_t                item,
    input  logic                               item_avail,
    input  logic [mrwq_pkg::LIM_W-1:0]         active_limit,
    output logic                               item_pop,
    output logic                               done,
    output logic [mrwq_pkg::STATUS_W-1:0]      status,
    output logic [mrwq_pkg::HANDLE_W-1:0]      head_handle,
    output logic [mrwq_pkg::CREATOR_W-1:0]     head_creator,
    output logic                               flush_busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_RESP
    } state_t;

    typedef logic [mrwq_pkg::PTR_W-1:0]      ptr_t;
    typedef logic [mrwq_pkg::GEN_WIDTH-1:0]  gen_t;
    typedef logic [mrwq_pkg::QIDX_W-1:0]     qidx_t;
    typedef logic [mrwq_pkg::SLOT_W-1:0]     slot_t;

    // slot storage
    logic [mrwq_pkg::HANDLE_W-1:0]   mem_handle  [mrwq_pkg::SLOTS];
    logic [mrwq_pkg::CREATOR_W-1:0]  mem_creator [mrwq_pkg::SLOTS];
    gen_t                            mem_gen     [mrwq_pkg::SLOTS];
    logic [mrwq_pkg::HANDLE_W-1:0]   rd_handle_reg;
    logic [mrwq_pkg::CREATOR_W-1:0]  rd_creator_reg;
    gen_t                            rd_gen_reg;
    logic                            mem_we;
    slot_t                           wr_addr;
    slot_t                           rd_addr;

    // control and queue state
    state_t                          state_reg, state_next;
    ptr_t                            wp_reg [mrwq_pkg::NUM_QUEUES];
    ptr_t                            wp_next [mrwq_pkg::NUM_QUEUES];
    ptr_t                            rp_reg [mrwq_pkg::NUM_QUEUES];
    ptr_t                            rp_next [mrwq_pkg::NUM_QUEUES];
    gen_t                            head_gen_reg [mrwq_pkg::NUM_QUEUES];
    gen_t                            head_gen_next [mrwq_pkg::NUM_QUEUES];
    gen_t                            gen_reg, gen_next;
    qidx_t                           qsel_reg, qsel_next;
    mrwq_pkg::cmd_t                  cmd_reg, cmd_next;
    mrwq_pkg::status_t               res_status_reg, res_status_next;
    logic [mrwq_pkg::HANDLE_W-1:0]   res_handle_reg, res_handle_next;
    logic [mrwq_pkg::CREATOR_W-1:0]  res_creator_reg, res_creator_next;
    logic                            done_reg, done_next;
    logic [mrwq_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [mrwq_pkg::HANDLE_W-1:0]   head_handle_reg, head_handle_next;
    logic [mrwq_pkg::CREATOR_W-1:0]  head_creator_reg, head_creator_next;
    logic                            flush_busy_reg, flush_busy_next;

    // current queue view
    qidx_t                           q;
    ptr_t                            w, r, w_nx, r_nx;
    logic [mrwq_pkg::NUM_QUEUES-1:0] stale;

    function automatic ptr_t next_ptr(input ptr_t p);
        if (int'(p) == mrwq_pkg::DEPTH - 1)
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    function automatic slot_t slot_of(input qidx_t qi, input ptr_t p);
        return slot_t'(qi) * slot_t'(mrwq_pkg::DEPTH) + slot_t'(p);
    endfunction

    assign q        = qidx_t'(item.section);
    assign w        = wp_reg[q];
    assign r        = rp_reg[q];
    assign w_nx     = next_ptr(w);
    assign r_nx     = next_ptr(r);
    assign item_pop = (state_reg == S_IDLE) && item_avail;

    assign wr_addr  = slot_of(q, w);
    assign rd_addr  = (item.cmd == mrwq_pkg::CMD_ISSUE) ? slot_of(q, r) : slot_of(q, r_nx);
    assign mem_we   = item_pop && (item.kind == mrwq_pkg::KIND_QUEUE)
                      && (item.cmd == mrwq_pkg::CMD_ENQ) && (w_nx != r);

    // head older than the current generation, per active queue
    always_comb
    begin
        gen_t d;
        for (int i = 0; i < mrwq_pkg::NUM_QUEUES; i++)
        begin
            d        = gen_reg - head_gen_reg[i];
            stale[i] = (i < int'(active_limit)) && (wp_reg[i] != rp_reg[i])
                       && (d != '0) && !d[mrwq_pkg::GEN_WIDTH-1];
        end
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        wp_next           = wp_reg;
        rp_next           = rp_reg;
        head_gen_next     = head_gen_reg;
        gen_next          = gen_reg;
        qsel_next         = qsel_reg;
        cmd_next          = cmd_reg;
        res_status_next   = res_status_reg;
        res_handle_next   = res_handle_reg;
        res_creator_next  = res_creator_reg;
        done_next         = 1'b0;
        status_next       = status_reg;
        head_handle_next  = head_handle_reg;
        head_creator_next = head_creator_reg;
        flush_busy_next   = flush_busy_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_avail)
                begin
                    qsel_next        = q;
                    cmd_next         = item.cmd;
                    res_status_next  = mrwq_pkg::ST_OK;
                    res_handle_next  = '0;
                    res_creator_next = '0;
                    state_next       = S_RESP;
                    unique case (item.kind)
                        mrwq_pkg::KIND_FLUSH:
                        begin
                            gen_next = gen_reg + 1'b1;
                        end
                        mrwq_pkg::KIND_BAD:
                        begin
                            res_status_next = mrwq_pkg::ST_BAD;
                        end
                        mrwq_pkg::KIND_QUEUE:
                        begin
                            unique case (item.cmd)
                                mrwq_pkg::CMD_ENQ:
                                begin
                                    if (w_nx == r)
                                    begin
                                        res_status_next = mrwq_pkg::ST_FULL;
                                    end
                                    else
                                    begin
                                        wp_next[q] = w_nx;
                                        if (w == r)
                                        begin
                                            head_gen_next[q] = gen_reg;
                                        end
                                    end
                                end
                                mrwq_pkg::CMD_ISSUE:
                                begin
                                    if (w == r)
                                    begin
                                        res_status_next = mrwq_pkg::ST_EMPTY;
                                    end
                                    else
                                    begin
                                        state_next = S_READ;
                                    end
                                end
                                mrwq_pkg::CMD_RETIRE:
                                begin
                                    if (w == r)
                                    begin
                                        res_status_next = mrwq_pkg::ST_EMPTY;
                                    end
                                    else
                                    begin
                                        rp_next[q] = r_nx;
                                        if (r_nx != w)
                                        begin
                                            state_next = S_READ;
                                        end
                                    end
                                end
                                mrwq_pkg::CMD_FLUSH:
                                begin
                                    // classified as flush by the front
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                // slot data is registered from the address presented in the idle state
                if (cmd_reg == mrwq_pkg::CMD_ISSUE)
                begin
                    res_handle_next  = rd_handle_reg;
                    res_creator_next = rd_creator_reg;
                end
                else
                begin
                    head_gen_next[qsel_reg] = rd_gen_reg;
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                done_next         = 1'b1;
                status_next       = res_status_reg;
                head_handle_next  = res_handle_reg;
                head_creator_next = res_creator_reg;
                flush_busy_next   = |stale;
                state_next        = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            wp_reg           <= '{default: '0};
            rp_reg           <= '{default: '0};
            head_gen_reg     <= '{default: '0};
            gen_reg          <= '0;
            qsel_reg         <= '0;
            cmd_reg          <= mrwq_pkg::CMD_ENQ;
            res_status_reg   <= mrwq_pkg::ST_OK;
            res_handle_reg   <= '0;
            res_creator_reg  <= '0;
            done_reg         <= 1'b0;
            status_reg       <= '0;
            head_handle_reg  <= '0;
            head_creator_reg <= '0;
            flush_busy_reg   <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            wp_reg           <= wp_next;
            rp_reg           <= rp_next;
            head_gen_reg     <= head_gen_next;
            gen_reg          <= gen_next;
            qsel_reg         <= qsel_next;
            cmd_reg          <= cmd_next;
            res_status_reg   <= res_status_next;
            res_handle_reg   <= res_handle_next;
            res_creator_reg  <= res_creator_next;
            done_reg         <= done_next;
            status_reg       <= status_next;
            head_handle_reg  <= head_handle_next;
            head_creator_reg <= head_creator_next;
            flush_busy_reg   <= flush_busy_next;
        end
    end

    // slot memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_handle[wr_addr]  <= item.handle;
            mem_creator[wr_addr] <= item.creator;
            mem_gen[wr_addr]     <= gen_reg;
        end
        rd_handle_reg  <= mem_handle[rd_addr];
        rd_creator_reg <= mem_creator[rd_addr];
        rd_gen_reg     <= mem_gen[rd_addr];
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign head_handle  = head_handle_reg;
    assign head_creator = head_creator_reg;
    assign flush_busy   = flush_busy_reg;

endmodule

// ===== rtl/mrwq_checker.sv =====
module mrwq_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic                               done,
    input  logic [mrwq_pkg::STATUS_W-1:0]      status,
    input  logic [mrwq_pkg::HANDLE_W-1:0]      head_handle,
    input  logic [mrwq_pkg::CREATOR_W-1:0]     head_creator
);

    logic [2:0] pending_reg;
    logic [2:0] pending_next;
    logic       accept;

    assign accept = start && !busy;

    // transactions accepted and not yet answered
    always_comb
    begin
        pending_next = pending_reg;
        if (accept && !done)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (done && !accept)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // every result answers an earlier transaction
    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> pending_reg != '0)
        else $error("result without an outstanding transaction");

    // command queue plus the one in execution bounds the backlog
    a_backlog_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd4)
        else $error("more transactions in flight than the design can hold");

    // the sequencer passes through idle between two results
    a_done_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("results on adjacent cycles");

    // head fields carry data only for a successful issue
    a_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != 2'(mrwq_pkg::ST_OK) |-> head_handle == '0 && head_creator == '0)
        else $error("head fields nonzero on a failed command");

endmodule

bind multi_ring_write_queue_with_flush mrwq_checker u_mrwq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .head_handle  (head_handle),
    .head_creator (head_creator)
);

// ===== tb/sv/multi_ring_write_queue_with_flush_tb.sv =====
module multi_ring_write_queue_with_flush_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mrwq_pkg::*;

    localparam int STALL_LIMIT      = 4000;
    localparam int DRAIN_CYCLES     = 8;
    localparam int RANDOM_PER_PHASE = 230;
    localparam int BURST_LEN        = 40;
    localparam int FLUSH_RUN        = 40;

    // one response of the queue bank
    typedef struct packed {
        status_t              status;
        logic [HANDLE_W-1:0]  head_handle;
        logic [CREATOR_W-1:0] head_creator;
        logic                 flush_busy;
    } response_t;

    // shadow of the queue bank and the responses still owed
    class ring_bank_scoreboard;
        logic [HANDLE_W-1:0]  slot_handle  [NUM_QUEUES][DEPTH];
        logic [CREATOR_W-1:0] slot_creator [NUM_QUEUES][DEPTH];
        logic [GEN_WIDTH-1:0] slot_gen     [NUM_QUEUES][DEPTH];
        logic [PTR_W-1:0]     wr_ptr [NUM_QUEUES];
        logic [PTR_W-1:0]     rd_ptr [NUM_QUEUES];
        logic [GEN_WIDTH-1:0] generation;
        logic [CFG_W-1:0]     active_count;
        response_t            pending_responses [$];
        int                   errors;

        function new();
            generation   = '0;
            active_count = ACTIVE_RESET;
            errors       = 0;
            foreach (wr_ptr[q])
            begin
                wr_ptr[q] = '0;
                rd_ptr[q] = '0;
            end
        endfunction

        function logic [PTR_W-1:0] advance(logic [PTR_W-1:0] p);
            return (int'(p) + 1 >= DEPTH) ? '0 : p + 1'b1;
        endfunction

        function int queue_limit();
            return (int'(active_count) > NUM_QUEUES) ? NUM_QUEUES : int'(active_count);
        endfunction

        // some active head older than the current generation, wrap-safe
        function logic stale_head();
            logic [GEN_WIDTH-1:0] age;
            for (int q = 0; q < queue_limit(); q++)
            begin
                if (rd_ptr[q] != wr_ptr[q])
                begin
                    age = generation - slot_gen[q][rd_ptr[q]];
                    if (age != '0 && !age[GEN_WIDTH-1])
                        return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        // update the shadow bank for an accepted command and queue its response
        function void apply_command(cmd_t c, logic [SEC_W-1:0] sec,
                                    logic [HANDLE_W-1:0] h, logic [CREATOR_W-1:0] cr);
            response_t r;
            r = '0;
            r.status = ST_OK;
            if (c == CMD_FLUSH)
                generation = generation + 1'b1;
            else if (int'(sec) >= queue_limit())
                r.status = ST_BAD;
            else if (c == CMD_ENQ)
            begin
                if (advance(wr_ptr[sec]) == rd_ptr[sec])
                    r.status = ST_FULL;
                else
                begin
                    slot_handle[sec][wr_ptr[sec]]  = h;
                    slot_creator[sec][wr_ptr[sec]] = cr;
                    slot_gen[sec][wr_ptr[sec]]     = generation;
                    wr_ptr[sec] = advance(wr_ptr[sec]);
                end
            end
            else if (wr_ptr[sec] == rd_ptr[sec])
                r.status = ST_EMPTY;
            else if (c == CMD_ISSUE)
            begin
                r.head_handle  = slot_handle[sec][rd_ptr[sec]];
                r.head_creator = slot_creator[sec][rd_ptr[sec]];
            end
            else
                rd_ptr[sec] = advance(rd_ptr[sec]);
            r.flush_busy = stale_head();
            pending_responses.push_back(r);
        endfunction

        // compare one response against the oldest one owed
        function void check_response(logic [STATUS_W-1:0] st, logic [HANDLE_W-1:0] hh,
                                     logic [CREATOR_W-1:0] hc, logic fb);
            response_t want;
            if (pending_responses.size() == 0)
            begin
                $display("%0t: response with none pending: status %0d handle %h creator %h",
                         $time, st, hh, hc);
                errors++;
                return;
            end
            want = pending_responses.pop_front();
            if (st !== want.status)
            begin
                $display("%0t: status expected %0d got %0d", $time, want.status, st);
                errors++;
            end
            if (hh !== want.head_handle)
            begin
                $display("%0t: head_handle expected %h got %h", $time, want.head_handle, hh);
                errors++;
            end
            if (hc !== want.head_creator)
            begin
                $display("%0t: head_creator expected %h got %h", $time, want.head_creator, hc);
                errors++;
            end
            if (fb !== want.flush_busy)
            begin
                $display("%0t: flush_busy expected %b got %b", $time, want.flush_busy, fb);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [CMD_W-1:0]     cmd;
    logic [SEC_W-1:0]     section;
    logic [HANDLE_W-1:0]  handle;
    logic [CREATOR_W-1:0] creator;
    logic                 cfg_we;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 done;
    logic [STATUS_W-1:0]  status;
    logic [HANDLE_W-1:0]  head_handle;
    logic [CREATOR_W-1:0] head_creator;
    logic                 flush_busy;

    ring_bank_scoreboard bank;
    int                  idle_pct;

    multi_ring_write_queue_with_flush dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .section      (section),
        .handle       (handle),
        .creator      (creator),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .done         (done),
        .status       (status),
        .head_handle  (head_handle),
        .head_creator (head_creator),
        .flush_busy   (flush_busy)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // monitor: accepted commands and response strobes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                bank.apply_command(cmd_t'(cmd), section, handle, creator);
            if (done)
                bank.check_response(status, head_handle, head_creator, flush_busy);
        end
    end

    // watchdog on cycles with no transaction on either side
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                quiet = 0;
            else
                quiet++;
        end
        $display("multi_ring_write_queue_with_flush_tb NOT OK");
        $finish;
    end

    // present one command, with random sender gaps, until it is taken
    task automatic send_command(cmd_t c, logic [SEC_W-1:0] sec,
                                logic [HANDLE_W-1:0] h, logic [CREATOR_W-1:0] cr);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start   <= 1'b1;
        cmd     <= c;
        section <= sec;
        handle  <= h;
        creator <= cr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    // random command, biased toward filling or draining a hot queue
    task automatic send_random(int lim, int hot, bit filling);
        int               roll;
        int               pick;
        cmd_t             c;
        logic [SEC_W-1:0] sec;
        roll = $urandom_range(99);
        if (roll < 8)
            c = CMD_FLUSH;
        else if (roll < (filling ? 60 : 35))
            c = CMD_ENQ;
        else if (roll < (filling ? 75 : 55))
            c = CMD_ISSUE;
        else
            c = CMD_RETIRE;
        pick = $urandom_range(99);
        if (lim > 0 && pick < 50)
            sec = SEC_W'(hot);
        else if (lim > 0 && pick < 85)
            sec = SEC_W'($urandom_range(lim - 1));
        else
            sec = SEC_W'($urandom_range(7));
        send_command(c, sec, $urandom, CREATOR_W'($urandom_range(16'hFFFF)));
    endtask

    // stop issuing and wait until every response is in
    task automatic drain();
        start <= 1'b0;
        while (bank.pending_responses.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_active(logic [CFG_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        bank.active_count = v;
    endtask

    // stimulus
    initial
    begin
        logic [CFG_W-1:0] settings [8];
        int               idle_table [3];
        int               lim;
        int               hot;
        bit               filling;

        settings   = '{4'd1, 4'd15, 4'd0, 4'd4, 4'd8, 4'd2, 4'd12, 4'd6};
        idle_table = '{0, 83, 32};
        bank       = new();
        idle_pct   = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        cmd        = '0;
        section    = '0;
        handle     = '0;
        creator    = '0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty queue, field extremes, full queue, flush, pointer wrap
        send_command(CMD_ISSUE, '0, '0, '0);
        send_command(CMD_RETIRE, '0, '0, '0);
        send_command(CMD_ENQ, '0, 32'h0000_0000, 16'h0000);
        send_command(CMD_ENQ, '0, 32'hFFFF_FFFF, 16'hFFFF);
        repeat (5) send_command(CMD_ENQ, '0, $urandom, CREATOR_W'($urandom_range(16'hFFFF)));
        send_command(CMD_ENQ, '0, 32'h1234_5678, 16'h9ABC);
        send_command(CMD_ISSUE, '0, '0, '0);
        send_command(CMD_FLUSH, 3'd7, 32'hFFFF_FFFF, 16'hFFFF);
        send_command(CMD_RETIRE, '0, '0, '0);
        send_command(CMD_ISSUE, '0, '0, '0);
        send_command(CMD_ENQ, 3'd7, 32'h8000_0001, 16'h8001);
        send_command(CMD_ISSUE, 3'd7, '0, '0);
        send_command(CMD_RETIRE, 3'd7, '0, '0);
        send_command(CMD_RETIRE, 3'd7, '0, '0);
        repeat (2) send_command(CMD_RETIRE, '0, '0, '0);
        repeat (2) send_command(CMD_ENQ, '0, $urandom, CREATOR_W'($urandom_range(16'hFFFF)));
        send_command(CMD_ISSUE, '0, '0, '0);

        // age a lone head across a run of flushes
        send_command(CMD_ENQ, 3'd3, $urandom, CREATOR_W'($urandom_range(16'hFFFF)));
        repeat (FLUSH_RUN)
            send_command(CMD_FLUSH, SEC_W'($urandom_range(7)), $urandom,
                         CREATOR_W'($urandom_range(16'hFFFF)));
        send_command(CMD_RETIRE, 3'd3, '0, '0);

        // random phases over active counts and sender idling
        for (int p = 0; p < 8; p++)
        begin
            drain();
            write_active(settings[p]);
            idle_pct = idle_table[p % 3];
            lim      = (int'(settings[p]) > NUM_QUEUES) ? NUM_QUEUES : int'(settings[p]);
            hot      = 0;
            filling  = 1'b0;
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                if (i % BURST_LEN == 0)
                begin
                    hot     = (lim > 0) ? $urandom_range(lim - 1) : 0;
                    filling = !filling;
                end
                send_random(lim, hot, filling);
            end
        end

        drain();
        if (bank.errors == 0 && bank.pending_responses.size() == 0)
            $display("multi_ring_write_queue_with_flush_tb OK");
        else
            $display("multi_ring_write_queue_with_flush_tb NOT OK");
        $finish;
    end

endmodule
